### hw/rtl/sll_pkg.sv
package sll_pkg;

  localparam int unsigned Depth    = 64;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned ValW     = 32;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeDelete = 2'd1;
  localparam logic [1:0] ModeFind   = 2'd2;
  localparam logic [1:0] ModeNone   = 2'd3;

  localparam logic [2:0] StatOk       = 3'd0;
  localparam logic [2:0] StatNotFound = 3'd1;
  localparam logic [2:0] StatEmpty    = 3'd2;
  localparam logic [2:0] StatFull     = 3'd3;
  localparam logic [2:0] StatNan      = 3'd4;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ValW-1:0] value;
  } sll_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ValW-1:0] found_value;
    logic [6:0]      entry_count;
  } sll_out_t;

  function automatic logic is_nan(input logic [ValW-1:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // monotonic unsigned key, both zeros alike
  function automatic logic [ValW-1:0] order_key(input logic [ValW-1:0] b);
    if (b[30:0] == 31'd0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return b | 32'h8000_0000;
  endfunction

endpackage

### hw/rtl/sorted_list_insert_delete_find.sv
// rejected items and no-ops go from idle straight to done; other items first scan
// the entries in order, then an insert or delete shifts the entries behind the found
// position; the scan and the shift both go through the single memory port
// the next item is taken the cycle after the result is loaded; the result has its
// own register, so a waiting result stalls only the finish of the following item
// reset clears the count and control; list contents are not cleared
module sorted_list_insert_delete_find import sll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sll_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sll_out_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle, StSearch, StShiftUp, StShiftDn, StDone
  } state_e;

  logic [ValW-1:0] mem_q [Depth];
  logic [ValW-1:0] rd_q;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] pos_q;
  logic            rd_ok_q;
  logic [1:0]      mode_q;
  logic [ValW-1:0] val_q;
  logic [ValW-1:0] key_q;
  logic [2:0]      stat_q;
  logic [ValW-1:0] found_q;
  sll_out_t        res_q;
  logic            out_valid_q;
  logic            out_free;

  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [ValW-1:0] mem_wd;
  logic [IdxW-1:0] mem_ra;
  logic            rd_en;

  logic [ValW-1:0] rd_key;
  assign rd_key = order_key(rd_q);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (rd_en)  rd_q <= mem_q[mem_ra];
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q[IdxW-1:0];
    mem_wd = val_q;
    rd_en  = 1'b0;
    mem_ra = idx_q[IdxW-1:0];
    case (state_q)
      StSearch: begin
        rd_en = 1'b1;
      end
      StShiftUp: begin
        // idx moves down from cnt; read idx-1 then write it to idx
        rd_en  = 1'b1;
        mem_ra = IdxW'(idx_q - CntW'(1));
        if (rd_ok_q) begin
          mem_we = 1'b1;
          mem_wa = IdxW'(idx_q + CntW'(1));
          mem_wd = rd_q;
        end
      end
      StShiftDn: begin
        rd_en  = 1'b1;
        mem_ra = IdxW'(idx_q + CntW'(1));
        if (rd_ok_q) begin
          mem_we = 1'b1;
          mem_wa = IdxW'(idx_q - CntW'(1));
          mem_wd = rd_q;
        end
      end
      StDone: begin
        if (mode_q == ModeInsert && stat_q == StatOk) begin
          mem_we = 1'b1;
          mem_wa = pos_q[IdxW-1:0];
          mem_wd = val_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == StDone && stat_q == StatOk) begin
      if (mode_q == ModeInsert) cnt_d = cnt_q + CntW'(1);
      else if (mode_q == ModeDelete) cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      rd_ok_q     <= 1'b0;
      mode_q      <= ModeInsert;
      val_q       <= '0;
      key_q       <= '0;
      stat_q      <= StatOk;
      found_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StDone && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            mode_q  <= in_data_i.mode;
            val_q   <= in_data_i.value;
            key_q   <= order_key(in_data_i.value);
            idx_q   <= '0;
            rd_ok_q <= 1'b0;
            found_q <= '0;
            if (in_data_i.mode == ModeNone) begin
              stat_q  <= StatOk;
              state_q <= StDone;
            end else if (is_nan(in_data_i.value)) begin
              stat_q  <= StatNan;
              state_q <= StDone;
            end else if (in_data_i.mode == ModeInsert && cnt_q == CntW'(Depth)) begin
              stat_q  <= StatFull;
              state_q <= StDone;
            end else if (in_data_i.mode == ModeDelete && cnt_q == '0) begin
              stat_q  <= StatEmpty;
              state_q <= StDone;
            end else begin
              stat_q  <= StatOk;
              state_q <= StSearch;
            end
          end
        end
        StSearch: begin
          // rd_q holds entry idx-1 when rd_ok_q
          if (rd_ok_q && !(rd_key < key_q)) begin
            pos_q   <= idx_q - CntW'(1);
            rd_ok_q <= 1'b0;
            if (mode_q == ModeInsert) begin
              idx_q   <= cnt_q;
              state_q <= (cnt_q == idx_q - CntW'(1)) ? StDone : StShiftUp;
            end else if (rd_key != key_q) begin
              stat_q  <= StatNotFound;
              state_q <= StDone;
            end else if (mode_q == ModeFind) begin
              found_q <= rd_q;
              state_q <= StDone;
            end else begin
              idx_q   <= idx_q - CntW'(1);
              state_q <= StShiftDn;
            end
          end else if (idx_q == cnt_q) begin
            pos_q   <= cnt_q;
            rd_ok_q <= 1'b0;
            if (mode_q != ModeInsert) stat_q <= StatNotFound;
            state_q <= StDone;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            rd_ok_q <= 1'b1;
          end
        end
        StShiftUp: begin
          // copy entry idx-1 to idx, for idx from cnt down to pos+1
          if (rd_ok_q && idx_q == pos_q) begin
            state_q <= StDone;
          end else begin
            idx_q   <= idx_q - CntW'(1);
            rd_ok_q <= 1'b1;
          end
        end
        StShiftDn: begin
          // copy entry idx+1 to idx, for idx from pos up to cnt-2
          if (idx_q + CntW'(1) == cnt_q) begin
            state_q <= StDone;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            rd_ok_q <= 1'b1;
          end
        end
        StDone: begin
          // wait here while the previous result still sits in the output register
          if (out_free) begin
            cnt_q   <= cnt_d;
            res_q   <= '{status: stat_q, found_value: found_q, entry_count: 7'(cnt_d)};
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### test/sorted_list_insert_delete_find_checker.sv
`timescale 1ns / 100ps

module sorted_list_insert_delete_find_checker import sll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  sll_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  sll_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  logic [ValW-1:0] list_q [Depth];
  int unsigned     list_len;
  sll_out_t        answers_q [$];

  function automatic logic val_is_nan(logic [ValW-1:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [ValW-1:0] sort_key(logic [ValW-1:0] b);
    if (b[30:0] == 31'd0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return b | 32'h8000_0000;
  endfunction

  function automatic int unsigned first_not_less(logic [ValW-1:0] k);
    int unsigned i;
    i = 0;
    while (i < list_len && sort_key(list_q[i]) < k) i++;
    return i;
  endfunction

  task automatic apply_op(sll_in_t it);
    sll_out_t r;
    logic [ValW-1:0] k;
    int unsigned p;
    r = '0;
    k = sort_key(it.value);
    if (it.mode != ModeNone && val_is_nan(it.value)) begin
      r.status = StatNan;
    end else if (it.mode == ModeInsert) begin
      if (list_len >= Depth) begin
        r.status = StatFull;
      end else begin
        p = first_not_less(k);
        for (int j = list_len; j > p; j--) list_q[j] = list_q[j-1];
        list_q[p] = it.value;
        list_len++;
      end
    end else if (it.mode == ModeDelete) begin
      if (list_len == 0) begin
        r.status = StatEmpty;
      end else begin
        p = first_not_less(k);
        if (p < list_len && sort_key(list_q[p]) == k) begin
          for (int j = p; j + 1 < list_len; j++) list_q[j] = list_q[j+1];
          list_len--;
        end else begin
          r.status = StatNotFound;
        end
      end
    end else if (it.mode == ModeFind) begin
      p = first_not_less(k);
      if (p < list_len && sort_key(list_q[p]) == k) r.found_value = list_q[p];
      else r.status = StatNotFound;
    end
    r.entry_count = list_len[6:0];
    answers_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sll_out_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      list_len = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          want = answers_q.pop_front();
          if (want.status !== out_data_i.status) begin
            $error("status expected %0d actual %0d", want.status, out_data_i.status);
            errs++;
          end
          if (want.found_value !== out_data_i.found_value) begin
            $error("found_value expected %h actual %h", want.found_value,
                   out_data_i.found_value);
            errs++;
          end
          if (want.entry_count !== out_data_i.entry_count) begin
            $error("entry_count expected %0d actual %0d", want.entry_count,
                   out_data_i.entry_count);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_op(in_data_i);
      fail_count_o <= fail_count_o + errs;
      pending_o    <= answers_q.size();
    end
  end

endmodule

### test/sorted_list_insert_delete_find_test.sv
`timescale 1ns / 100ps

module sorted_list_insert_delete_find_test;
  import sll_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sll_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sll_out_t out_data;
  int       fail_count;
  int       pending;
  bit       quiet_mode = 1'b0;
  bit       hold_off = 1'b0;
  logic [ValW-1:0] pool [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_list_insert_delete_find dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  sorted_list_insert_delete_find_checker checker_u (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic send_item(logic [1:0] m, logic [ValW-1:0] v);
    while (!quiet_mode && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: m, value: v};
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [ValW-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return pool[4'($urandom_range(15))];
    if (pick == 6) return {1'($urandom_range(1)), 8'hFF, 22'($urandom), 1'b1};
    if (pick == 7) return {1'($urandom_range(1)), 31'd0};
    return $urandom;
  endfunction

  // receiver: random stalls, always ready in quiet mode, or solid stall while hold_off is set
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (quiet_mode) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 35);
  end

  initial begin
    int unsigned wait_n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    pool[0] = 32'h0000_0000; pool[1] = 32'h8000_0000;
    pool[2] = 32'h7F80_0000; pool[3] = 32'hFF80_0000;
    pool[4] = 32'h7F7F_FFFF; pool[5] = 32'h0000_0001;
    // directed: empty-list cases, zeros, infinities, nan, mode 3
    send_item(ModeDelete, 32'h3F80_0000);
    send_item(ModeFind, 32'h3F80_0000);
    send_item(ModeInsert, 32'h7FC0_0000);
    send_item(ModeDelete, 32'hFFFF_FFFF);
    send_item(ModeFind, 32'h7F80_0001);
    send_item(ModeInsert, 32'h8000_0000);
    send_item(ModeFind, 32'h0000_0000);
    send_item(ModeInsert, 32'h0000_0000);
    send_item(ModeInsert, 32'hFF80_0000);
    send_item(ModeInsert, 32'h7F80_0000);
    send_item(ModeInsert, 32'hBF80_0000);
    send_item(ModeInsert, 32'h3F80_0000);
    send_item(ModeNone, 32'h7FC0_0000);
    send_item(ModeFind, 32'hFF80_0000);
    send_item(ModeDelete, 32'h4000_0000);
    send_item(ModeDelete, 32'h0000_0000);
    send_item(ModeFind, 32'h8000_0000);
    send_item(ModeDelete, 32'h7F80_0000);
    // try to fill past full; the receiver holds off at first
    hold_off = 1'b1;
    fork
      begin
        repeat (70) send_item(ModeInsert, rand_value());
      end
      begin
        wait_n = 0;
        while (wait_n < 3000) begin
          @(posedge clk);
          wait_n++;
        end
        hold_off = 1'b0;
      end
    join
    repeat (70) send_item(ModeDelete, pool[4'($urandom_range(15))]);
    quiet_mode = 1'b1;
    repeat (100) send_item(2'($urandom_range(3)), rand_value());
    quiet_mode = 1'b0;
    repeat (400) begin
      wait_n = $urandom_range(99);
      send_item(wait_n < 45 ? ModeInsert : wait_n < 70 ? ModeDelete
                : wait_n < 97 ? ModeFind : ModeNone, rand_value());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
